@@ rtl/fmp_pkg.sv @@
// package: shared types, constants and index tables of the fundamental matrix block
package fmp_pkg;

	// default element width (signed fixed point)
	localparam int ELEMENT_BITS_DEF = 15;
	// result entry width, fixed by the output word
	localparam int ENTRY_W = 62;
	// element store and minor store depths
	localparam int ELEM_DEPTH  = 24;
	localparam int MINOR_DEPTH = 36;
	localparam int ELEM_AW     = $clog2(ELEM_DEPTH);
	localparam int MINOR_AW    = $clog2(MINOR_DEPTH);

	// input word actions
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	// one slot of work for the datapath
	typedef struct packed {
		logic                valid;
		logic                term;   // 1: determinant term, 0: minor half
		logic                half;   // minor: second product of the pair
		logic                first;  // term: first of six
		logic                last;   // term: last of six
		logic                neg;    // term: subtract
		logic [ELEM_AW-1:0]  ea0;
		logic [ELEM_AW-1:0]  ea1;
		logic [MINOR_AW-1:0] ma0;
		logic [MINOR_AW-1:0] ma1;
		logic [MINOR_AW-1:0] mw;
		logic [1:0]          row;
		logic [1:0]          col;
	} fmp_cmd_t;

	// element load request
	typedef struct packed {
		logic               en;
		logic [ELEM_AW-1:0] addr;
	} fmp_load_t;

	// datapath status
	typedef struct packed {
		logic busy;      // work still in the pipeline
		logic out_free;  // output register empty
	} fmp_sts_t;

	// cyclic row pair p: rows (p+1) mod 3 and (p+2) mod 3
	function automatic logic [1:0] row_a(input logic [1:0] p);
		logic [1:0] r;
		case (p)
			2'd0: r = 2'd1;
			2'd1: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] row_b(input logic [1:0] p);
		logic [1:0] r;
		case (p)
			2'd0: r = 2'd2;
			2'd1: r = 2'd0;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

	// column pairs (0,1) (0,2) (0,3) (1,2) (1,3) (2,3)
	function automatic logic [1:0] col_j(input logic [2:0] cp);
		logic [1:0] c;
		case (cp)
			3'd0, 3'd1, 3'd2: c = 2'd0;
			3'd3, 3'd4: c = 2'd1;
			default: c = 2'd2;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] col_k(input logic [2:0] cp);
		logic [1:0] c;
		case (cp)
			3'd0: c = 2'd1;
			3'd1, 3'd3: c = 2'd2;
			default: c = 2'd3;
		endcase
		return c;
	endfunction

	// element address camera*12 + row*4 + col
	function automatic logic [ELEM_AW-1:0] elem_addr(input logic cam, input logic [1:0] row,
			input logic [1:0] col);
		logic [ELEM_AW-1:0] base;
		base = cam ? ELEM_AW'(12) : '0;
		return base + ELEM_AW'({row, 2'b00}) + ELEM_AW'(col);
	endfunction

	// minor address camera*18 + rowpair*6 + colpair
	function automatic logic [MINOR_AW-1:0] minor_addr(input logic cam, input logic [1:0] rp,
			input logic [2:0] cp);
		logic [MINOR_AW-1:0] base;
		base = cam ? MINOR_AW'(18) : '0;
		return base + MINOR_AW'(rp) * MINOR_AW'(6) + MINOR_AW'(cp);
	endfunction

endpackage

@@ rtl/fmp_ram.sv @@
// generic ram: one write port, two registered read ports
module fmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

@@ rtl/fmp_ctrl.sv @@
// controller: sequences loads, minor build and determinant terms
module fmp_ctrl import fmp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_action,
	input  logic       in_cam,
	input  logic [1:0] in_row,
	input  logic [1:0] in_col,
	output logic       in_ready,
	input  fmp_sts_t   sts,
	output fmp_cmd_t   cmd,
	output fmp_load_t  load
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MINOR = 5'b00010,
		ST_MWAIT = 5'b00100,
		ST_TERM  = 5'b01000,
		ST_TWAIT = 5'b10000
	} fmp_state_t;

	fmp_state_t state_q;
	logic       cam_q;
	logic [1:0] rp_q;
	logic [2:0] cp_q;
	logic       half_q;
	logic [1:0] er_q;
	logic [1:0] ec_q;
	logic [2:0] k_q;
	logic       accept;
	logic       can_start;
	logic [1:0] ra, rb, cj, ck;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign can_start = !sts.busy && sts.out_free;

	// element loads
	assign load.en   = accept && (in_action == ACT_LOAD) && (in_row != 2'd3);
	assign load.addr = elem_addr(in_cam, in_row, in_col);

	// command for this cycle
	assign ra = row_a(rp_q);
	assign rb = row_b(rp_q);
	assign cj = col_j(cp_q);
	assign ck = col_k(cp_q);

	always_comb begin
		cmd       = '0;
		cmd.half  = half_q;
		cmd.first = (k_q == 3'd0);
		cmd.last  = (k_q == 3'd5);
		cmd.neg   = (k_q == 3'd1) || (k_q == 3'd4);
		cmd.row   = er_q;
		cmd.col   = ec_q;
		cmd.mw    = minor_addr(cam_q, rp_q, cp_q);
		cmd.ea0   = elem_addr(cam_q, ra, half_q ? ck : cj);
		cmd.ea1   = elem_addr(cam_q, rb, half_q ? cj : ck);
		cmd.ma0   = minor_addr(1'b0, ec_q, k_q);
		cmd.ma1   = minor_addr(1'b1, er_q, 3'd5 - k_q);
		case (state_q)
			ST_MINOR: begin
				cmd.valid = 1'b1;
				cmd.term  = 1'b0;
			end
			ST_TERM: begin
				cmd.valid = 1'b1;
				cmd.term  = 1'b1;
			end
			default: begin
				cmd.valid = 1'b0;
			end
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cam_q   <= 1'b0;
			rp_q    <= '0;
			cp_q    <= '0;
			half_q  <= 1'b0;
			er_q    <= '0;
			ec_q    <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && in_action == ACT_COMPUTE) begin
						state_q <= ST_MINOR;
						cam_q   <= 1'b0;
						rp_q    <= '0;
						cp_q    <= '0;
						half_q  <= 1'b0;
					end
				end
				ST_MINOR: begin
					half_q <= !half_q;
					if (half_q) begin
						if (cp_q == 3'd5) begin
							cp_q <= '0;
							if (rp_q == 2'd2) begin
								rp_q <= '0;
								cam_q <= !cam_q;
								if (cam_q) begin
									state_q <= ST_MWAIT;
								end
							end else begin
								rp_q <= rp_q + 2'd1;
							end
						end else begin
							cp_q <= cp_q + 3'd1;
						end
					end
				end
				ST_MWAIT: begin
					if (can_start) begin
						state_q <= ST_TERM;
						er_q    <= '0;
						ec_q    <= '0;
						k_q     <= '0;
					end
				end
				ST_TERM: begin
					if (k_q == 3'd5) begin
						k_q <= '0;
						if (ec_q == 2'd2) begin
							ec_q <= '0;
							er_q <= er_q + 2'd1;
						end else begin
							ec_q <= ec_q + 2'd1;
						end
						state_q <= (er_q == 2'd2 && ec_q == 2'd2) ? ST_IDLE : ST_TWAIT;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_TWAIT: begin
					if (can_start) begin
						state_q <= ST_TERM;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/fmp_dp.sv @@
// datapath: element and minor stores, shared multiplier, accumulator, output register
module fmp_dp import fmp_pkg::*; #(
	parameter int EB = ELEMENT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fmp_load_t          load,
	input  logic [14:0]        ld_data,
	input  fmp_cmd_t           cmd,
	output fmp_sts_t           sts,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_row,
	output logic [1:0]         out_col,
	output logic [ENTRY_W-1:0] out_value,
	output logic               out_last
);

	localparam int PW = 2 * EB;
	localparam int MW = PW + 1;
	localparam int QW = 2 * MW;

	fmp_cmd_t           cmd_s1, cmd_s2;
	logic [EB-1:0]      e0, e1;
	logic [MW-1:0]      m0, m1;
	logic [MW-1:0]      op_a, op_b;
	logic [QW-1:0]      prod_s2;
	logic [PW-1:0]      hold_q;
	logic [MW-1:0]      mdiff;
	logic               mwe;
	logic [ENTRY_W-1:0] acc_q, base, q, acc_nx;
	logic               out_valid_q;
	logic [1:0]         out_row_q, out_col_q;
	logic [ENTRY_W-1:0] out_value_q;
	logic               out_last_q;

	// element store
	fmp_ram #(.WIDTH(EB), .DEPTH(ELEM_DEPTH)) u_elem (
		.clk    (clk),
		.we     (load.en),
		.waddr  (load.addr),
		.wdata  (ld_data[EB-1:0]),
		.raddr0 (cmd.ea0),
		.raddr1 (cmd.ea1),
		.rdata0 (e0),
		.rdata1 (e1)
	);

	// 2x2 minor store
	fmp_ram #(.WIDTH(MW), .DEPTH(MINOR_DEPTH)) u_minor (
		.clk    (clk),
		.we     (mwe),
		.waddr  (cmd_s2.mw),
		.wdata  (mdiff),
		.raddr0 (cmd.ma0),
		.raddr1 (cmd.ma1),
		.rdata0 (m0),
		.rdata1 (m1)
	);

	// control pipeline alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
			cmd_s2 <= '0;
		end else begin
			cmd_s1 <= cmd;
			cmd_s2 <= cmd_s1;
		end
	end

	// shared multiplier: elements for minors, minors for terms
	assign op_a = cmd_s1.term ? m0 : MW'($signed(e0));
	assign op_b = cmd_s1.term ? m1 : MW'($signed(e1));

	always_ff @(posedge clk) begin
		prod_s2 <= QW'($signed(op_a) * $signed(op_b));
	end

	// minor = first product minus second product
	assign mdiff = MW'($signed(hold_q)) - MW'($signed(prod_s2[PW-1:0]));
	assign mwe   = cmd_s2.valid && !cmd_s2.term && cmd_s2.half;

	always_ff @(posedge clk) begin
		if (cmd_s2.valid && !cmd_s2.term && !cmd_s2.half) begin
			hold_q <= prod_s2[PW-1:0];
		end
	end

	// signed accumulation of the six terms
	assign q      = ENTRY_W'($signed(prod_s2));
	assign base   = cmd_s2.first ? '0 : acc_q;
	assign acc_nx = cmd_s2.neg ? base - q : base + q;

	always_ff @(posedge clk) begin
		if (cmd_s2.valid && cmd_s2.term) begin
			acc_q <= acc_nx;
		end
		if (cmd_s2.valid && cmd_s2.term && cmd_s2.last) begin
			out_value_q <= acc_nx;
			out_row_q   <= cmd_s2.row;
			out_col_q   <= cmd_s2.col;
			out_last_q  <= (cmd_s2.row == 2'd2) && (cmd_s2.col == 2'd2);
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_s2.valid && cmd_s2.term && cmd_s2.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.busy     = cmd_s1.valid || cmd_s2.valid;
	assign sts.out_free = !out_valid_q;
	assign out_valid    = out_valid_q;
	assign out_row      = out_row_q;
	assign out_col      = out_col_q;
	assign out_value    = out_value_q;
	assign out_last     = out_last_q;

endmodule

@@ rtl/fundamental_matrix_from_projections.sv @@
// top level: fundamental matrix from two 3x4 projection matrices
// A load word writes one projection element; one with row index 3 writes nothing. A compute
// word first builds all 36 two-by-two minors of both cameras through one shared multiplier,
// two element products per minor, then forms each of the nine 4x4 determinants from six
// minor products. Between entries the controller waits for the pipeline to drain into the
// output register and for the entry to be taken. The single output register holds one entry;
// the next entry starts once it is taken. Input is taken only between items, and opens again
// as soon as the last determinant has been issued.
module fundamental_matrix_from_projections import fmp_pkg::*; #(
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // which_camera, row_index[1:0], col_index[1:0], element_value[14:0]
	input  logic [0:0]  s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // out_row[1:0], out_col[1:0], entry_value[61:0]
	output logic        m_tlast
);

	fmp_cmd_t           cmd;
	fmp_load_t          load;
	fmp_sts_t           sts;
	logic [1:0]         out_row, out_col;
	logic [ENTRY_W-1:0] out_value;

	// controller
	fmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_action (s_tuser[0]),
		.in_cam    (s_tdata[0]),
		.in_row    (s_tdata[2:1]),
		.in_col    (s_tdata[4:3]),
		.in_ready  (s_tready),
		.sts       (sts),
		.cmd       (cmd),
		.load      (load)
	);

	// datapath
	fmp_dp #(.EB(ELEMENT_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.ld_data   (s_tdata[19:5]),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.out_last  (m_tlast)
	);

	// output word packing
	assign m_tdata = {6'd0, out_value, out_col, out_row};

endmodule

@@ rtl/fmp_checker.sv @@
// checker: port level assertions for the fundamental matrix block, and its bind
module fmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tlast
);

	// stalled output word stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	// last marks exactly the entry at row 2, column 2
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[1:0] == 2'd2 && m_tdata[3:2] == 2'd2)))
		else $error("last flag on wrong entry");

	// entry indexes within the 3x3 matrix
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'd3 && m_tdata[3:2] != 2'd3))
		else $error("entry index out of range");

	// a compute word closes the input side once it is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
		else $error("input open during compute");

endmodule

bind fundamental_matrix_from_projections fmp_checker u_fmp_checker (.*);

@@ test/tb_fundamental_matrix_from_projections.sv @@
// testbench: fundamental matrix block checked against an in-bench determinant predictor
module tb_fundamental_matrix_from_projections;
	import fmp_pkg::*;

	typedef struct packed {
		logic [1:0]  row;
		logic [1:0]  col;
		logic [61:0] value;
		logic        last;
	} fm_entry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tlast;

	fundamental_matrix_from_projections uut (.*);

	always #2 clk = ~clk;

	// predictor state: shadow of the projection store
	logic signed [14:0] proj [0:1][0:2][0:3];
	fm_entry_t          fm_pending [$];
	int                 errors = 0;
	int                 words_out = 0;
	int                 computes = 0;
	int                 loads = 0;
	int                 stall_on = 1;
	int                 idle_cnt = 0;

	function automatic logic signed [63:0] minor2(int cam, int ra, int rb, int j, int k);
		return 64'(proj[cam][ra][j]) * 64'(proj[cam][rb][k])
			- 64'(proj[cam][ra][k]) * 64'(proj[cam][rb][j]);
	endfunction

	// nine entries of f, row-major, from cyclic row pairs of both cameras
	task automatic predict_fmatrix();
		int xa, xb, ya, yb;
		logic signed [63:0] d;
		fm_entry_t e;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				xa = (c + 1) % 3; xb = (c + 2) % 3;
				ya = (r + 1) % 3; yb = (r + 2) % 3;
				d = minor2(0, xa, xb, 0, 1) * minor2(1, ya, yb, 2, 3)
					- minor2(0, xa, xb, 0, 2) * minor2(1, ya, yb, 1, 3)
					+ minor2(0, xa, xb, 0, 3) * minor2(1, ya, yb, 1, 2)
					+ minor2(0, xa, xb, 1, 2) * minor2(1, ya, yb, 0, 3)
					- minor2(0, xa, xb, 1, 3) * minor2(1, ya, yb, 0, 2)
					+ minor2(0, xa, xb, 2, 3) * minor2(1, ya, yb, 0, 1);
				e.row = 2'(r); e.col = 2'(c); e.value = d[61:0];
				e.last = (r == 2 && c == 2);
				fm_pending.push_back(e);
			end
	endtask

	// send one word, with optional random gap first; valid stays up for a following word
	task automatic send_word(logic act, logic cam, logic [1:0] row, logic [1:0] col,
			logic [14:0] val);
		if (stall_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {3'b000, val, col, row, cam};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (act == ACT_COMPUTE) begin
			predict_fmatrix();
			computes++;
		end else begin
			loads++;
			if (row != 2'd3) begin
				proj[cam][row][col] = val;
			end
		end
	endtask

	task automatic load_element(logic cam, logic [1:0] row, logic [1:0] col, logic [14:0] v);
		send_word(ACT_LOAD, cam, row, col, v);
	endtask

	task automatic compute_fmatrix();
		send_word(ACT_COMPUTE, 1'($urandom_range(0, 1)), 2'($urandom), 2'($urandom),
			15'($urandom));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (fm_pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [14:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return 15'h4000;
			1: return 15'h3fff;
			2: return 15'h0000;
			3: return 15'($urandom_range(0, 1023));
			default: return 15'($urandom);
		endcase
	endfunction

	task automatic load_all(int mode);
		for (int cam = 0; cam < 2; cam++)
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 4; c++)
					load_element(1'(cam), 2'(r), 2'(c),
						mode == 0 ? 15'h4000 : mode == 1 ? 15'h3fff : rand_elem());
	endtask

	// extremes: all most negative, then all most positive, then mixed sign
	task automatic test_extremes();
		load_all(0);
		compute_fmatrix();
		load_all(1);
		compute_fmatrix();
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 4; c++)
				load_element(1'b1, 2'(r), 2'(c), ((r + c) & 1) ? 15'h4000 : 15'h3fff);
		compute_fmatrix();
	endtask

	// row index 3 must leave the store alone
	task automatic test_row_ignored();
		load_element(1'b0, 2'd3, 2'd0, 15'h1234);
		load_element(1'b1, 2'd3, 2'd3, 15'h7fff);
		compute_fmatrix();
		compute_fmatrix();
	endtask

	// pause until every entry is out, then random traffic
	task automatic test_random(int n_items);
		int sent;
		sent = 0;
		drain();
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				load_element(1'($urandom_range(0, 1)), 2'd3, 2'($urandom), rand_elem());
			end else if ($urandom_range(0, 5) == 0) begin
				compute_fmatrix();
				sent++;
			end else begin
				load_element(1'($urandom_range(0, 1)), 2'($urandom_range(0, 2)),
					2'($urandom_range(0, 3)), rand_elem());
				sent++;
			end
			if (sent == n_items * 3 / 4) stall_on = 0;
		end
		compute_fmatrix();
	endtask

	// receiver stalls and result checks
	always @(posedge clk) begin
		fm_entry_t got, want;
		if (m_tvalid && m_tready) begin
			got.row = m_tdata[1:0]; got.col = m_tdata[3:2];
			got.value = m_tdata[65:4]; got.last = m_tlast;
			words_out++;
			if (fm_pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word %h", got);
			end else begin
				want = fm_pending.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp r%0d c%0d %h l%0d got r%0d c%0d %h l%0d",
							want.row, want.col, want.value, want.last,
							got.row, got.col, got.value, got.last);
				end
			end
		end
		if (idle_cnt > 0) begin
			idle_cnt <= idle_cnt - 1;
			m_tready <= 1'b0;
		end else if (stall_on && $urandom_range(0, 7) == 0) begin
			idle_cnt <= $urandom_range(1, 18);
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	// watchdog on cycles with no accepted word
	int quiet = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_row_ignored();
		test_random(250);
		drain();
		$display("covered %0d loads and %0d computes, %0d entries checked",
			loads, computes, words_out);
		if (errors == 0 && fm_pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/fmp_pkg.sv
rtl/fmp_ram.sv
rtl/fmp_ctrl.sv
rtl/fmp_dp.sv
rtl/fundamental_matrix_from_projections.sv
rtl/fmp_checker.sv
test/tb_fundamental_matrix_from_projections.sv
